@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the checker file of the page allocator.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, held off while reset is high.
`define BPA_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked through reset.
`define BPA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/bpa_pkg.sv @@
// Shared constants for the bitmap page allocator: field widths, opcodes,
// register indexes and register reset values. Depends on nothing.
package bpa_pkg;

  // Payload field widths
  localparam int OPCODE_W   = 2;
  localparam int ADDR_W     = 25;
  localparam int PAGE_NUM_W = 13;

  // Configuration port
  localparam int REG_W      = 14;
  localparam int APB_AW     = 5;
  localparam int APB_DW     = 32;
  localparam int REG_IDX_W  = 3;

  // Bitmap word geometry
  localparam int WORD_W      = 32;
  localparam int WORD_BITS_W = 5;

  // Default sizes
  localparam int PAGE_COUNT_DEF = 8192;
  localparam int PAGE_SHIFT_DEF = 12;

  typedef logic [REG_W-1:0]     reg_t;
  typedef logic [OPCODE_W-1:0]  opcode_t;
  typedef logic [REG_IDX_W-1:0] reg_idx_t;

  // Operation codes
  localparam opcode_t OP_ALLOC = 2'd0;
  localparam opcode_t OP_FREE  = 2'd1;
  localparam opcode_t OP_QUERY = 2'd2;
  localparam opcode_t OP_INIT  = 2'd3;

  // Register indexes
  localparam reg_idx_t REG_KERNEL_FIRST = 3'd0;
  localparam reg_idx_t REG_KERNEL_END   = 3'd1;
  localparam reg_idx_t REG_STACK_FIRST  = 3'd2;
  localparam reg_idx_t REG_STACK_END    = 3'd3;
  localparam reg_idx_t REG_HEAP_FIRST   = 3'd4;
  localparam reg_idx_t REG_HEAP_END     = 3'd5;

  // Register reset values
  localparam reg_t KERNEL_FIRST_RST = 14'd256;
  localparam reg_t KERNEL_END_RST   = 14'd512;
  localparam reg_t STACK_FIRST_RST  = 14'd512;
  localparam reg_t STACK_END_RST    = 14'd768;
  localparam reg_t HEAP_FIRST_RST   = 14'd768;
  localparam reg_t HEAP_END_RST     = 14'd1792;

endpackage

@@ hw/rtl/bpa_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module bpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/bitmap_page_allocator.sv @@
// Bitmap page allocator top level: APB register file, operation sequencer and
// the bitmap RAM. Depends on bpa_pkg and bpa_ram.
//
// The used map is held as 32-bit words in one RAM (PAGE_COUNT/32 words, 256 at
// the default size), and every operation walks that RAM one word per cycle
// through its single read port and single write port. An alloc reads the hint
// word from idle, then checks each word in turn up to the first word
// with a free page (at most PAGE_COUNT/32 words); a free or a query reads its
// word from idle, then writes or checks it; an init writes every word in turn.
// One item is in work at a time; a new item is taken while the previous result
// still waits in the output register. After reset a clearing pass writes every
// word to zero, taking no item meanwhile; register writes are taken throughout.
module bitmap_page_allocator #(
  parameter int PAGE_COUNT = bpa_pkg::PAGE_COUNT_DEF,
  parameter int PAGE_SHIFT = bpa_pkg::PAGE_SHIFT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // Configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bpa_pkg::APB_AW-1:0]     paddr,
  input  logic [bpa_pkg::APB_DW-1:0]     pwdata,
  output logic [bpa_pkg::APB_DW-1:0]     prdata,
  output logic                           pready,
  // Request channel
  input  logic                           req_valid,
  output logic                           req_ready,
  input  logic [bpa_pkg::OPCODE_W-1:0]   opcode,
  input  logic [bpa_pkg::ADDR_W-1:0]     address,
  input  logic [bpa_pkg::PAGE_NUM_W-1:0] page_number,
  // Response channel
  output logic                           rsp_valid,
  input  logic                           rsp_ready,
  output logic [bpa_pkg::ADDR_W-1:0]     page_address,
  output logic                           page_is_free
);

  import bpa_pkg::*;

  localparam int NWORDS    = (PAGE_COUNT + WORD_W - 1) / WORD_W;
  localparam int WA        = $clog2(NWORDS);
  localparam int PW        = WA + WORD_BITS_W;
  localparam int HW        = ($clog2(PAGE_COUNT + 1) > REG_W) ? $clog2(PAGE_COUNT + 1) : REG_W;
  localparam int CW        = HW + 1;
  localparam int CNT_W     = WORD_BITS_W + 1;
  localparam int TW        = WORD_W + 1;
  localparam int LAST_BITS = PAGE_COUNT - (NWORDS - 1) * WORD_W;
  localparam logic [WA-1:0] LAST_WORD = WA'(NWORDS - 1);

  // Sequencer states
  localparam logic [2:0] S_CLR   = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_FREE  = 3'd3;
  localparam logic [2:0] S_QUERY = 3'd4;
  localparam logic [2:0] S_INIT  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  // Mask with the low n bits set, n from 0 to 32
  function automatic logic [WORD_W-1:0] thermo(input logic [CNT_W-1:0] n);
    logic [TW-1:0] t;
    t = TW'(1) << n;
    thermo = WORD_W'(t - TW'(1));
  endfunction

  // Position of a range edge inside word w, clamped to 0..32
  function automatic logic [CNT_W-1:0] clamp_edge(input reg_t v, input logic [WA-1:0] w);
    logic [CW-1:0] ve;
    logic [CW-1:0] be;
    ve = CW'(v);
    be = CW'({w, WORD_BITS_W'(0)});
    if (ve <= be) begin
      clamp_edge = '0;
    end else if (ve >= be + CW'(WORD_W)) begin
      clamp_edge = CNT_W'(WORD_W);
    end else begin
      clamp_edge = CNT_W'(ve - be);
    end
  endfunction

  // Bits of word w that fall in the half-open range [f, e)
  function automatic logic [WORD_W-1:0] range_mask(input reg_t f, input reg_t e,
                                                   input logic [WA-1:0] w);
    range_mask = thermo(clamp_edge(e, w)) & ~thermo(clamp_edge(f, w));
  endfunction

  // Configuration registers
  reg_t kernel_first;
  reg_t kernel_limit;
  reg_t stack_first;
  reg_t stack_limit;
  reg_t heap_first;
  reg_t heap_limit;

  // Sequencer registers
  logic [2:0]             state, state_next;
  logic [WA-1:0]          word, word_next;
  logic [WORD_BITS_W-1:0] lo_bits, lo_bits_next;
  logic [WORD_BITS_W-1:0] bit_sel, bit_sel_next;
  logic [HW-1:0]          hint, hint_next;
  logic [ADDR_W-1:0]      res_addr, res_addr_next;
  logic                   res_free, res_free_next;
  logic                   rsp_valid_next;
  logic [ADDR_W-1:0]      page_address_next;
  logic                   page_is_free_next;

  // RAM port
  logic                   ram_we;
  logic [WA-1:0]          ram_waddr;
  logic [WORD_W-1:0]      ram_wdata;
  logic [WA-1:0]          ram_raddr;
  logic [WORD_W-1:0]      ram_rdata;

  // Request decode
  logic                   req_fire;
  logic [ADDR_W-1:0]      rel_page_full;
  logic                   free_in_range;
  logic [PW-1:0]          rel_page;
  logic                   query_in_range;
  logic [PW-1:0]          query_page;
  logic                   hint_in_range;

  // Scan datapath
  logic [WORD_W-1:0]      valid_mask;
  logic [WORD_W-1:0]      avail;
  logic [WORD_W-1:0]      pick;
  logic [WORD_BITS_W-1:0] pick_idx;
  logic [PW-1:0]          pick_page;
  logic [PW-1:0]          held_page;
  logic [WORD_W-1:0]      init_word;

  bpa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NWORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Configuration write and read-back
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_first <= KERNEL_FIRST_RST;
      kernel_limit <= KERNEL_END_RST;
      stack_first  <= STACK_FIRST_RST;
      stack_limit  <= STACK_END_RST;
      heap_first   <= HEAP_FIRST_RST;
      heap_limit   <= HEAP_END_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[APB_AW-1:2])
        REG_KERNEL_FIRST: kernel_first <= pwdata[REG_W-1:0];
        REG_KERNEL_END:   kernel_limit <= pwdata[REG_W-1:0];
        REG_STACK_FIRST:  stack_first  <= pwdata[REG_W-1:0];
        REG_STACK_END:    stack_limit  <= pwdata[REG_W-1:0];
        REG_HEAP_FIRST:   heap_first   <= pwdata[REG_W-1:0];
        REG_HEAP_END:     heap_limit   <= pwdata[REG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[APB_AW-1:2])
      REG_KERNEL_FIRST: prdata = APB_DW'(kernel_first);
      REG_KERNEL_END:   prdata = APB_DW'(kernel_limit);
      REG_STACK_FIRST:  prdata = APB_DW'(stack_first);
      REG_STACK_END:    prdata = APB_DW'(stack_limit);
      REG_HEAP_FIRST:   prdata = APB_DW'(heap_first);
      REG_HEAP_END:     prdata = APB_DW'(heap_limit);
      default:          prdata = '0;
    endcase
  end

  // Decode the request beat
  assign req_ready      = (state == S_IDLE);
  assign req_fire       = req_valid && req_ready;
  assign rel_page_full  = address >> PAGE_SHIFT;
  assign free_in_range  = rel_page_full < ADDR_W'(PAGE_COUNT);
  assign rel_page       = PW'(rel_page_full);
  assign query_in_range = 32'(page_number) < PAGE_COUNT;
  assign query_page     = PW'(page_number);
  assign hint_in_range  = hint < HW'(PAGE_COUNT);

  // Find the lowest free page of the word under scan
  always_comb begin
    valid_mask = (word == LAST_WORD) ? thermo(CNT_W'(LAST_BITS)) : '1;
    avail      = ~ram_rdata & ~thermo(CNT_W'(lo_bits)) & valid_mask;
    pick       = avail & (~avail + WORD_W'(1));
    pick_idx   = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (pick[i]) begin
        pick_idx = pick_idx | WORD_BITS_W'(i);
      end
    end
    pick_page = {word, pick_idx};
    held_page = {word, bit_sel};
  end

  // Word of the reserved map that init writes
  always_comb begin
    init_word = range_mask(kernel_first, kernel_limit, word)
              | range_mask(stack_first, stack_limit, word)
              | range_mask(heap_first, heap_limit, word);
    if (word == '0) begin
      init_word[0] = 1'b1;
    end
  end

  // Sequencer
  always_comb begin
    state_next        = state;
    word_next         = word;
    lo_bits_next      = lo_bits;
    bit_sel_next      = bit_sel;
    hint_next         = hint;
    res_addr_next     = res_addr;
    res_free_next     = res_free;
    rsp_valid_next    = rsp_valid;
    page_address_next = page_address;
    page_is_free_next = page_is_free;
    ram_we            = 1'b0;
    ram_waddr         = word;
    ram_wdata         = '0;
    ram_raddr         = word;

    // Drop the response once taken
    if (rsp_valid && rsp_ready) begin
      rsp_valid_next = 1'b0;
    end

    case (state)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
        if (word == LAST_WORD) begin
          word_next  = '0;
          state_next = S_IDLE;
        end else begin
          word_next = word + WA'(1);
        end
      end

      S_IDLE: begin
        if (req_fire) begin
          res_addr_next = '0;
          res_free_next = 1'b0;
          case (opcode)
            OP_ALLOC: begin
              if (hint_in_range) begin
                ram_raddr    = hint[PW-1:WORD_BITS_W];
                word_next    = hint[PW-1:WORD_BITS_W];
                lo_bits_next = hint[WORD_BITS_W-1:0];
                state_next   = S_SCAN;
              end else begin
                state_next = S_DONE;
              end
            end
            OP_FREE: begin
              if (free_in_range) begin
                ram_raddr    = rel_page[PW-1:WORD_BITS_W];
                word_next    = rel_page[PW-1:WORD_BITS_W];
                bit_sel_next = rel_page[WORD_BITS_W-1:0];
                state_next   = S_FREE;
              end else begin
                state_next = S_DONE;
              end
            end
            OP_QUERY: begin
              if (query_in_range) begin
                ram_raddr    = query_page[PW-1:WORD_BITS_W];
                word_next    = query_page[PW-1:WORD_BITS_W];
                bit_sel_next = query_page[WORD_BITS_W-1:0];
                state_next   = S_QUERY;
              end else begin
                state_next = S_DONE;
              end
            end
            default: begin
              word_next  = '0;
              state_next = S_INIT;
            end
          endcase
        end
      end

      S_SCAN: begin
        // Read ahead to the next word while checking this one
        ram_raddr = (word == LAST_WORD) ? word : word + WA'(1);
        if (avail != '0) begin
          ram_we        = 1'b1;
          ram_wdata     = ram_rdata | pick;
          hint_next     = HW'(pick_page) + HW'(1);
          res_addr_next = ADDR_W'(pick_page) << PAGE_SHIFT;
          state_next    = S_DONE;
        end else if (word == LAST_WORD) begin
          state_next = S_DONE;
        end else begin
          word_next    = word + WA'(1);
          lo_bits_next = '0;
        end
      end

      S_FREE: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata & ~(WORD_W'(1) << bit_sel);
        if (HW'(held_page) < hint) begin
          hint_next = HW'(held_page);
        end
        state_next = S_DONE;
      end

      S_QUERY: begin
        res_free_next = ~ram_rdata[bit_sel];
        state_next    = S_DONE;
      end

      S_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = init_word;
        if (word == LAST_WORD) begin
          hint_next  = HW'(kernel_limit);
          state_next = S_DONE;
        end else begin
          word_next = word + WA'(1);
        end
      end

      S_DONE: begin
        // Hold the result until the output register is free
        if (!rsp_valid || rsp_ready) begin
          rsp_valid_next    = 1'b1;
          page_address_next = res_addr;
          page_is_free_next = res_free;
          state_next        = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      word      <= '0;
      hint      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      word      <= word_next;
      hint      <= hint_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    lo_bits      <= lo_bits_next;
    bit_sel      <= bit_sel_next;
    res_addr     <= res_addr_next;
    res_free     <= res_free_next;
    page_address <= page_address_next;
    page_is_free <= page_is_free_next;
  end

endmodule

@@ hw/rtl/bpa_checker.sv @@
// Port-level checker for the bitmap page allocator, bound to the top level.
// Depends on bpa_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bpa_checker #(
  parameter int PAGE_SHIFT = bpa_pkg::PAGE_SHIFT_DEF
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_ready,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic [bpa_pkg::ADDR_W-1:0]   page_address,
  input logic                         page_is_free
);

  import bpa_pkg::*;

  // Stalled response beat holds its payload
  `BPA_ASSERT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready |=> rsp_valid && $stable(page_address) && $stable(page_is_free), "stalled response beat changed")

  // Reset empties the output and starts the clearing pass
  `BPA_ASSERT_ALWAYS(a_rst_quiet, clk, rst |=> !rsp_valid && !req_ready, "busy or valid after reset")

  // Only an alloc gives an address and only a query reports free
  `BPA_ASSERT(a_fields_excl, clk, rst, rsp_valid |-> !(page_address != '0 && page_is_free), "address and free flag both set")

  // Allocated addresses are page aligned
  `BPA_ASSERT(a_page_align, clk, rst, rsp_valid |-> page_address[PAGE_SHIFT-1:0] == '0, "page address not aligned")

endmodule

bind bitmap_page_allocator bpa_checker #(
  .PAGE_SHIFT (PAGE_SHIFT)
) u_bpa_checker (
  .clk          (clk),
  .rst          (rst),
  .req_ready    (req_ready),
  .rsp_valid    (rsp_valid),
  .rsp_ready    (rsp_ready),
  .page_address (page_address),
  .page_is_free (page_is_free)
);
